// File: rtl/core/sme_pkg.sv
// shared types and constants for the sparse product symbolic expansion core
// no dependencies
package sme_pkg;

	localparam int ADDR_W    = 10;
	localparam int DATA_W    = 11;
	localparam int ROWPTR_W  = 11;
	localparam int COL_W     = 6;
	localparam int COUNT_W   = 32;
	localparam int RESULT_CAP = 64;
	localparam int CAP_W     = 7;

	typedef enum logic [1:0] {
		OP_LOAD_ROW = 2'd0,
		OP_LOAD_COL = 2'd1,
		OP_NONZERO  = 2'd2,
		OP_BOUNDARY = 2'd3
	} op_t;

	localparam logic KIND_ROWPTR = 1'b0;
	localparam logic KIND_COLUMN = 1'b1;

	typedef struct packed {
		logic wr_row;
		logic wr_col;
		logic rd_row_in;
		logic rd_row_next;
		logic setup;
		logic issue;
		logic emit_col;
		logic emit_count;
	} cmd_t;

	typedef struct packed {
		logic col_ok;
		logic row_addr_ok;
		logic col_addr_ok;
		logic nonempty;
		logic rem_zero;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/sme_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/sme_ctrl.sv
// controller: sequences loads, row boundaries and row expansion
// depends on sme_pkg
module sme_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    operation,
	input  sme_pkg::sts_t sts,
	output sme_pkg::cmd_t cmd
);
	import sme_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	logic   acc;
	op_t    op;

	assign op = op_t'(operation);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		pend_d   = pend_q;
		in_ready = 1'b0;
		acc      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = (op != OP_BOUNDARY) || sts.out_free;
				acc      = in_valid && in_ready;
				if (acc) begin
					case (op)
						OP_LOAD_ROW: cmd.wr_row = sts.row_addr_ok;
						OP_LOAD_COL: cmd.wr_col = sts.col_addr_ok;
						OP_BOUNDARY: cmd.emit_count = 1'b1;
						OP_NONZERO: begin
							if (sts.col_ok) begin
								cmd.rd_row_in = 1'b1;
								state_d       = ST_START;
							end
						end
						default: ;
					endcase
				end
			end
			ST_START: begin
				cmd.rd_row_next = 1'b1;
				state_d         = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.setup = 1'b1;
				pend_d    = 1'b0;
				state_d   = sts.nonempty ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit_col = pend_q && sts.out_free;
				cmd.issue    = !sts.rem_zero && (!pend_q || sts.out_free);
				if (cmd.issue) begin
					pend_d = 1'b1;
				end else if (cmd.emit_col) begin
					pend_d = 1'b0;
				end
				if (sts.rem_zero && (!pend_q || cmd.emit_col)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// File: rtl/core/sme_dp.sv
// datapath: b matrix stores, row walk counters, running count and output word
// depends on sme_pkg and sme_ram
module sme_dp #(
	parameter int B_ROWS_MAX = 256,
	parameter int B_NNZ_MAX  = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sme_pkg::ADDR_W-1:0]   address,
	input  logic [sme_pkg::DATA_W-1:0]   data,
	input  sme_pkg::cmd_t                cmd,
	output sme_pkg::sts_t                sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         kind,
	output logic [sme_pkg::COUNT_W-1:0]  value,
	output logic                         last
);
	import sme_pkg::*;

	localparam int RW = $clog2(B_ROWS_MAX + 1);
	localparam int CW = (B_NNZ_MAX > 1) ? $clog2(B_NNZ_MAX) : 1;

	logic [31:0]         addr_ext, data_ext, idx_ext, col_next_ext;
	logic [RW-1:0]       col_q;
	logic [RW-1:0]       row_raddr;
	logic [ROWPTR_W-1:0] row_rdata;
	logic [ROWPTR_W-1:0] start_q;
	logic [ROWPTR_W-1:0] end_clip;
	logic [ROWPTR_W-1:0] span;
	logic [ROWPTR_W-1:0] idx_q;
	logic [CAP_W-1:0]    rem_q;
	logic                pend_last_q;
	logic [COL_W-1:0]    col_rdata;
	logic [COUNT_W-1:0]  count_q;
	logic                ov_q, kind_q, last_q;
	logic [COUNT_W-1:0]  value_q;

	assign addr_ext     = 32'(address);
	assign data_ext     = 32'(data);
	assign idx_ext      = 32'(idx_q);
	assign col_next_ext = 32'(col_q) + 32'd1;

	assign row_raddr = cmd.rd_row_next ? col_next_ext[RW-1:0] : data_ext[RW-1:0];

	sme_ram #(
		.WIDTH(ROWPTR_W),
		.DEPTH(B_ROWS_MAX + 1)
	) u_row_ram (
		.clk   (clk),
		.we    (cmd.wr_row),
		.waddr (addr_ext[RW-1:0]),
		.wdata (data[ROWPTR_W-1:0]),
		.re    (cmd.rd_row_in || cmd.rd_row_next),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	sme_ram #(
		.WIDTH(COL_W),
		.DEPTH(B_NNZ_MAX)
	) u_col_ram (
		.clk   (clk),
		.we    (cmd.wr_col),
		.waddr (addr_ext[CW-1:0]),
		.wdata (data[COL_W-1:0]),
		.re    (cmd.issue),
		.raddr (idx_ext[CW-1:0]),
		.rdata (col_rdata)
	);

	// end pointer is clipped to the store depth when it exceeds B_NNZ_MAX; the 11-bit pointer stays below 2048
	always_comb begin
		if (32'(row_rdata) > B_NNZ_MAX) begin
			end_clip = ROWPTR_W'(B_NNZ_MAX);
		end else begin
			end_clip = row_rdata;
		end
		span = end_clip - start_q;
	end

	assign sts.col_ok      = data_ext < B_ROWS_MAX;
	assign sts.row_addr_ok = addr_ext <= B_ROWS_MAX;
	assign sts.col_addr_ok = addr_ext < B_NNZ_MAX;
	assign sts.nonempty    = end_clip > start_q;
	assign sts.rem_zero    = (rem_q == '0);
	assign sts.out_free    = !ov_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.rd_row_in) begin
			col_q <= data_ext[RW-1:0];
		end
		if (cmd.rd_row_next) begin
			start_q <= row_rdata;
		end
		if (cmd.issue) begin
			pend_last_q <= (rem_q == CAP_W'(1));
		end
		if (cmd.emit_count) begin
			kind_q  <= KIND_ROWPTR;
			value_q <= count_q;
			last_q  <= 1'b1;
		end else if (cmd.emit_col) begin
			kind_q  <= KIND_COLUMN;
			value_q <= COUNT_W'(col_rdata);
			last_q  <= pend_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			count_q <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.emit_count || cmd.emit_col) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cmd.emit_col && (count_q != '1)) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (cmd.setup) begin
				idx_q <= start_q;
				if (!sts.nonempty) begin
					rem_q <= '0;
				end else if (32'(span) > RESULT_CAP) begin
					rem_q <= CAP_W'(RESULT_CAP);
				end else begin
					rem_q <= span[CAP_W-1:0];
				end
			end else if (cmd.issue) begin
				idx_q <= idx_q + ROWPTR_W'(1);
				rem_q <= rem_q - CAP_W'(1);
			end
		end
	end

	assign out_valid = ov_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// File: rtl/core/sparse_matmul_symbolic_expand_core.sv
// top level of the sparse product symbolic expansion core
// depends on sme_pkg, sme_ctrl, sme_dp and sme_ram
//
// usage: first load the right matrix through the input channel, row pointer words
// (operation 0) and column index words (operation 1); each load is taken while the
// core is idle and gives no output. then stream the left matrix: a row boundary word
// (operation 3) gives one output word holding the running column count, a nonzero
// word (operation 2) gives the column indices of the addressed right-matrix row,
// one output word per cycle while the receiver takes them, at most 64, the final one marked last.
// a boundary word shows on the output in the cycle after it is taken. a nonzero
// walks two row pointer reads, a setup step, then one column ram read per cycle
// while the receiver keeps up; an empty row ends after the setup step, and a column
// out of range is taken with no output. the single read port of the column ram
// sets that rate.
// both channels are valid/ready; the output register lets the next word be taken
// while a result waits, except a boundary word, which waits for the register. a
// stalled receiver holds the row walk in place without loss.
// reset clears the running count and all control state; the stores are undefined
// until loaded.
module sparse_matmul_symbolic_expand_core #(
	parameter int B_ROWS_MAX = 256,
	parameter int B_NNZ_MAX  = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [sme_pkg::ADDR_W-1:0]  address,
	input  logic [sme_pkg::DATA_W-1:0]  data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic [sme_pkg::COUNT_W-1:0] value,
	output logic                        last
);
	import sme_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sme_dp #(
		.B_ROWS_MAX(B_ROWS_MAX),
		.B_NNZ_MAX (B_NNZ_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.address   (address),
		.data      (data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	a_boundary_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (operation == OP_BOUNDARY))
		|=> (out_valid && (kind == KIND_ROWPTR) && last))
		else $error("boundary word not presented");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || cmd.emit_col || cmd.setup || cmd.rd_row_next) |-> !in_ready)
		else $error("input taken during row walk");

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_col || cmd.emit_count) |-> sts.out_free)
		else $error("output word overwritten");

	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_col |-> !cmd.emit_count)
		else $error("two sources load the output word");

endmodule
